@@ hdl/tcw_pkg.sv @@
// Shared types and constants for the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

    // Cell address width, wide enough for 256 x 64 = 16384 cells
    localparam int CA_W = 14;

    // Command queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] SPACE_CHAR   = 8'h20;
    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [7:0] RESET_ATTR   = 8'h0B;

    localparam logic [3:0] RAINBOW_FIRST = 4'd1;
    localparam logic [3:0] RAINBOW_LAST  = 4'd15;

    // Configuration register indexes
    localparam logic [0:0] REG_TEXT_COLOR   = 1'b0;
    localparam logic [0:0] REG_RAINBOW_MODE = 1'b1;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // One classified item as handed from front to back
    typedef struct packed {
        t_op             kind;
        logic            wr_en;       // put writes a cell (not a newline)
        logic [CA_W-1:0] addr;        // write address for put, read address for read
        logic [15:0]     data;        // cell for put, fill cell for clear
        logic            blank;       // put scrolls: blank one row
        logic [CA_W-1:0] blank_addr;  // first cell of the row to blank
        logic            rd_ok;       // read index inside the screen
        logic [4:0]      row;         // cursor after this item
        logic [6:0]      col;
        logic            scrolled;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_FILL
    } t_back_state;

endpackage

@@ hdl/tcw_front.sv @@
// Front end: takes items, tracks cursor, scroll base and colors, builds commands.
`timescale 1ns / 1ps

module tcw_front
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_character,
    input  logic        i_first,
    input  logic [10:0] i_cell_index,
    input  logic        i_cfg_valid,
    input  logic [0:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    output t_cmd        o_cmd
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int COL_W = $clog2(COLUMNS);
    localparam int ROW_W = $clog2(ROWS);

    localparam logic [AW:0]      CELLS_X  = (AW+1)'(CELLS);
    localparam logic [AW:0]      COLS_X   = (AW+1)'(COLUMNS);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic [AW-1:0]    r_cur, n_cur;     // physical address of the cursor cell
    logic [AW-1:0]    r_base, n_base;   // physical address of logical row 0
    logic [3:0]       r_fg, n_fg;
    logic [7:0]       r_text_color;
    logic             r_rainbow;

    t_op          op;
    logic [3:0]   fg_use;
    logic [3:0]   fg_next;
    logic [7:0]   attr;
    logic         is_nl;
    logic         wrap_row;
    logic         at_last_row;
    logic [AW:0]  row_start;
    logic [AW:0]  next_sum;
    logic [AW-1:0] next_start;
    logic [AW:0]  base_sum;
    logic [AW-1:0] base_next;
    logic         rd_ok;
    logic [AW:0]  rd_sum;
    logic [AW:0]  rd_wrap;
    t_cmd         cmd;

    assign op = t_op'(i_op);

    // Attribute in effect for a put and the following rainbow step
    assign fg_use  = i_first ? RAINBOW_FIRST : r_fg;
    assign fg_next = (fg_use == RAINBOW_LAST) ? RAINBOW_FIRST : fg_use + 4'd1;
    assign attr    = r_rainbow ? {4'h0, fg_use} : r_text_color;

    assign is_nl       = (i_character == NEWLINE_CHAR);
    assign wrap_row    = is_nl || (r_col == LAST_COL);
    assign at_last_row = (r_row == LAST_ROW);

    // Start of the next physical row; rows are contiguous in a ring
    assign row_start  = {1'b0, r_cur} - (AW+1)'(r_col);
    assign next_sum   = row_start + COLS_X;
    assign next_start = (next_sum == CELLS_X) ? '0 : next_sum[AW-1:0];

    assign base_sum   = {1'b0, r_base} + COLS_X;
    assign base_next  = (base_sum == CELLS_X) ? '0 : base_sum[AW-1:0];

    // Logical read index to physical address
    assign rd_ok   = (32'(i_cell_index) < 32'(CELLS));
    assign rd_sum  = {1'b0, AW'(i_cell_index)} + {1'b0, r_base};
    assign rd_wrap = (rd_sum >= CELLS_X) ? rd_sum - CELLS_X : rd_sum;

    // Classify the item and compute the next cursor state
    always_comb begin
        n_row  = r_row;
        n_col  = r_col;
        n_cur  = r_cur;
        n_base = r_base;
        n_fg   = r_fg;
        cmd    = '0;
        cmd.kind = op;
        case (op)
            OP_PUT: begin
                cmd.wr_en = !is_nl;
                cmd.addr  = CA_W'(r_cur);
                cmd.data  = {attr, i_character};
                if (r_rainbow) begin
                    n_fg = fg_next;
                end
                if (wrap_row) begin
                    n_col = '0;
                    if (at_last_row) begin
                        // scroll: old top row becomes the blank bottom row
                        n_cur          = r_base;
                        n_base         = base_next;
                        cmd.blank      = 1'b1;
                        cmd.blank_addr = CA_W'(r_base);
                        cmd.scrolled   = 1'b1;
                    end else begin
                        n_row = r_row + 1'b1;
                        n_cur = next_start;
                    end
                end else begin
                    n_col = r_col + 1'b1;
                    n_cur = r_cur + 1'b1;
                end
            end
            OP_READ: begin
                cmd.rd_ok = rd_ok;
                cmd.addr  = CA_W'(rd_wrap[AW-1:0]);
            end
            OP_CLEAR: begin
                cmd.data = {r_text_color, SPACE_CHAR};
                n_row    = '0;
                n_col    = '0;
                n_cur    = '0;
                n_base   = '0;
            end
            default: begin
            end
        endcase
        cmd.row = 5'(n_row);
        cmd.col = 7'(n_col);
    end

    assign o_cmd = cmd;

    // Cursor, ring base and rainbow state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_cur  <= '0;
            r_base <= '0;
            r_fg   <= RAINBOW_FIRST;
        end else if (i_accept) begin
            r_row  <= n_row;
            r_col  <= n_col;
            r_cur  <= n_cur;
            r_base <= n_base;
            r_fg   <= n_fg;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= RESET_ATTR;
            r_rainbow    <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_TEXT_COLOR:   r_text_color <= i_cfg_data;
                REG_RAINBOW_MODE: r_rainbow    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

endmodule

@@ hdl/tcw_queue.sv @@
// Short command queue between front and back.
`timescale 1ns / 1ps

module tcw_queue
    import tcw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty,
    output logic o_full
);

    t_cmd               r_slots [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    assign o_cmd   = r_slots[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ hdl/tcw_back.sv @@
// Back end: screen memory, cell writes, reads, row blanking and screen fills.
`timescale 1ns / 1ps

module tcw_back
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic        i_empty,
    output logic        o_pop,
    output logic        o_init,
    output logic        o_done,
    output logic [15:0] o_cell_value,
    output logic [4:0]  o_cursor_row,
    output logic [6:0]  o_cursor_column,
    output logic        o_scrolled
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);

    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
    localparam logic [AW-1:0] ROW_SPAN  = AW'(COLUMNS - 1);

    logic [15:0] r_cells [CELLS];
    logic [15:0] r_rd_data;

    t_back_state r_state, n_state;
    logic [AW-1:0] r_fill_addr, n_fill_addr;
    logic [AW-1:0] r_fill_end, n_fill_end;
    logic [15:0]   r_fill_data, n_fill_data;
    t_cmd          r_hold, n_hold;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;
    logic          rd_en;
    logic          emit;
    t_cmd          emit_cmd;
    logic [15:0]   emit_value;

    logic          r_done;
    logic [15:0]   r_value;
    logic [4:0]    r_row;
    logic [6:0]    r_col;
    logic          r_scrolled;

    // Sequencer: one command at a time, fills take one cell per cycle
    always_comb begin
        n_state     = r_state;
        n_fill_addr = r_fill_addr;
        n_fill_end  = r_fill_end;
        n_fill_data = r_fill_data;
        n_hold      = r_hold;
        o_pop       = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = r_fill_addr;
        wr_data     = r_fill_data;
        rd_en       = 1'b0;
        emit        = 1'b0;
        emit_cmd    = i_cmd;
        emit_value  = 16'h0000;
        case (r_state)
            ST_INIT: begin
                wr_en       = 1'b1;
                wr_data     = {RESET_ATTR, SPACE_CHAR};
                n_fill_addr = r_fill_addr + 1'b1;
                if (r_fill_addr == LAST_CELL) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop  = 1'b1;
                    n_hold = i_cmd;
                    case (i_cmd.kind)
                        OP_PUT: begin
                            wr_en   = i_cmd.wr_en;
                            wr_addr = AW'(i_cmd.addr);
                            wr_data = i_cmd.data;
                            if (i_cmd.blank) begin
                                n_fill_addr = AW'(i_cmd.blank_addr);
                                n_fill_end  = AW'(i_cmd.blank_addr) + ROW_SPAN;
                                n_fill_data = {i_cmd.data[15:8], SPACE_CHAR};
                                n_state     = ST_FILL;
                            end else begin
                                emit = 1'b1;
                            end
                        end
                        OP_READ: begin
                            if (i_cmd.rd_ok) begin
                                rd_en   = 1'b1;
                                n_state = ST_READ;
                            end else begin
                                emit = 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            n_fill_addr = '0;
                            n_fill_end  = LAST_CELL;
                            n_fill_data = i_cmd.data;
                            n_state     = ST_FILL;
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                emit       = 1'b1;
                emit_cmd   = r_hold;
                emit_value = r_rd_data;
                n_state    = ST_IDLE;
            end
            ST_FILL: begin
                wr_en       = 1'b1;
                n_fill_addr = r_fill_addr + 1'b1;
                if (r_fill_addr == r_fill_end) begin
                    emit     = 1'b1;
                    emit_cmd = r_hold;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_init = (r_state == ST_INIT);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_fill_addr <= '0;
            r_fill_end  <= LAST_CELL;
            r_done      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill_addr <= n_fill_addr;
            r_fill_end  <= n_fill_end;
            r_done      <= emit;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_fill_data <= n_fill_data;
        r_hold      <= n_hold;
        if (emit) begin
            r_value    <= emit_value;
            r_row      <= emit_cmd.row;
            r_col      <= emit_cmd.col;
            r_scrolled <= emit_cmd.scrolled;
        end
    end

    // Screen memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_cells[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_cells[AW'(i_cmd.addr)];
        end
    end

    assign o_done          = r_done;
    assign o_cell_value    = r_value;
    assign o_cursor_row    = r_row;
    assign o_cursor_column = r_col;
    assign o_scrolled      = r_scrolled;

endmodule

@@ hdl/text_console_writer_top.sv @@
// Top level of the text console writer: front, command queue and back.
`timescale 1ns / 1ps
//
// Character-cell text console, COLUMNS x ROWS cells of 16 bits.
// Items: drive i_op/i_character/i_first/i_cell_index with start; a beat is
// taken at a rising edge with start high and busy low.
// Results: one per item, in order, shown for exactly one cycle with o_done
// high; the receiver must take it then, it cannot hold results off.
// Configuration: i_cfg_valid with i_cfg_index/i_cfg_data, o_cfg_ready is
// always high; write only while no item is in flight.
// Flow: an accepted item is registered in the queue; the back end takes it
// when free and registers its result; a read also waits for the memory read.
// The back end ends one command before it takes the next: a put that does not
// scroll only writes its cell, a scrolling put also blanks a row (one blank cell
// written per cycle on the single memory write port), a clear fills every cell.
// Rows sit in a ring, so a scroll only blanks one row and moves the base.
// The queue holds four commands; busy rises when it is full.
// Reset (synchronous, active low) homes the cursor, restores the registers,
// then a clearing pass writes all COLUMNS * ROWS cells (2000 by default) to
// light-cyan space with busy high.
//

module text_console_writer_top
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_character,
    input  logic        i_first,
    input  logic [10:0] i_cell_index,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    output logic        o_done,
    output logic [15:0] o_cell_value,
    output logic [4:0]  o_cursor_row,
    output logic [6:0]  o_cursor_column,
    output logic        o_scrolled
);

    logic accept;
    t_cmd front_cmd;
    t_cmd head_cmd;
    logic q_empty;
    logic q_full;
    logic pop;
    logic back_init;

    assign busy        = q_full || back_init;
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_op         (i_op),
        .i_character  (i_character),
        .i_first      (i_first),
        .i_cell_index (i_cell_index),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_cmd        (front_cmd)
    );

    tcw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (head_cmd),
        .i_empty         (q_empty),
        .o_pop           (pop),
        .o_init          (back_init),
        .o_done          (o_done),
        .o_cell_value    (o_cell_value),
        .o_cursor_row    (o_cursor_row),
        .o_cursor_column (o_cursor_column),
        .o_scrolled      (o_scrolled)
    );

endmodule

@@ hdl/tcw_checker.sv @@
// Port-level checks for the text console writer, bound to the top level.
`timescale 1ns / 1ps

module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        busy,
    input logic        o_done,
    input logic [15:0] o_cell_value,
    input logic [4:0]  o_cursor_row,
    input logic [6:0]  o_cursor_column,
    input logic        o_scrolled
);

    localparam logic       COL_FITS = (COLUMNS <= 128);
    localparam logic       ROW_FITS = (ROWS <= 32);
    localparam logic [4:0] LAST_ROW = 5'(ROWS - 1);

    // Reset starts the clearing pass, so no item can be taken right after it
    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("busy low right after reset");

    // No result can come out of a reset
    a_no_done_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result strobe right after reset");

    // Reported cursor stays on the screen
    a_cursor_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((!COL_FITS || (32'(o_cursor_column) < 32'(COLUMNS)))
                 && (!ROW_FITS || (32'(o_cursor_row) < 32'(ROWS)))))
        else $error("cursor reported off screen");

    // A scroll leaves the cursor at the start of the last row, no cell data
    a_scroll_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_scrolled) |-> ((o_cursor_column == 7'd0)
                 && (o_cursor_row == LAST_ROW) && (o_cell_value == 16'h0000)))
        else $error("scroll result with wrong cursor or cell value");

endmodule

bind text_console_writer_top tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .busy            (busy),
    .o_done          (o_done),
    .o_cell_value    (o_cell_value),
    .o_cursor_row    (o_cursor_row),
    .o_cursor_column (o_cursor_column),
    .o_scrolled      (o_scrolled)
);

@@ tb/tb_text_console_writer_top.sv @@
// Self-checking testbench for the text console writer top level.
`timescale 1ns / 1ps

module tb_text_console_writer_top;
    import tcw_pkg::*;

    localparam int COLUMNS = 80;
    localparam int ROWS = 25;
    localparam int CELLS = COLUMNS * ROWS;
    // A clear or the reset fill rewrites every cell; give it room before any write
    localparam int SETTLE_CYCLES = CELLS + 100;
    // Worst case is every item a full-screen clear plus sender gaps, taken ~5x over
    localparam int CYCLE_LIMIT = 20_000_000;
    localparam int ITEMS_PER_PHASE = 536;
    localparam int MAX_PRINTED = 100;

    typedef struct packed {
        t_op         op;
        logic [7:0]  ch;
        logic        first;
        logic [10:0] idx;
    } t_console_item;

    typedef struct packed {
        logic [15:0] value;
        logic [4:0]  row;
        logic [6:0]  col;
        logic        scrolled;
    } t_console_result;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind       kind;
        t_console_item   item;
        int              reps;
        bit              typed;
        t_console_result want;
        logic [0:0]      reg_idx;
        logic [7:0]      reg_val;
    } t_directed_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_op;
    logic [7:0]  i_character;
    logic        i_first;
    logic [10:0] i_cell_index;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;
    logic        o_done;
    logic [15:0] o_cell_value;
    logic [4:0]  o_cursor_row;
    logic [6:0]  o_cursor_column;
    logic        o_scrolled;

    // Shadow copy of the console state
    logic [15:0] shadow_screen [CELLS];
    int          shadow_row;
    int          shadow_col;
    logic [3:0]  shadow_hue;
    logic [7:0]  shadow_color;
    logic        shadow_rainbow;

    t_console_result pending_results [$];
    t_console_result oldest_result;
    t_directed_row   directed_rows [$];
    int              mismatches;
    int              gap_pct;
    int unsigned     cycles = 0;

    text_console_writer_top #(
        .COLUMNS(COLUMNS),
        .ROWS(ROWS)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_op(i_op),
        .i_character(i_character),
        .i_first(i_first),
        .i_cell_index(i_cell_index),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .o_done(o_done),
        .o_cell_value(o_cell_value),
        .o_cursor_row(o_cursor_row),
        .o_cursor_column(o_cursor_column),
        .o_scrolled(o_scrolled)
    );

    // 50 MHz clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Run watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("text_console_writer_top regression: fail");
            $finish;
        end
    end

    task automatic fill_shadow(input logic [7:0] attr);
        for (int i = 0; i < CELLS; i++) shadow_screen[i] = {attr, SPACE_CHAR};
    endtask

    // Move to the start of the next row, scrolling off the top when past the last row
    task automatic line_feed(input logic [7:0] attr, output logic rolled);
        rolled = 1'b0;
        shadow_col = 0;
        shadow_row++;
        if (shadow_row >= ROWS) begin
            for (int i = 0; i < CELLS - COLUMNS; i++) shadow_screen[i] = shadow_screen[i + COLUMNS];
            for (int i = CELLS - COLUMNS; i < CELLS; i++) shadow_screen[i] = {attr, SPACE_CHAR};
            shadow_row = ROWS - 1;
            rolled = 1'b1;
        end
    endtask

    // Apply one item to the shadow console and work out its result
    task automatic console_step(input t_console_item it, output t_console_result res);
        logic [7:0] attr;
        logic       rolled;
        res = '0;
        rolled = 1'b0;
        case (it.op)
            OP_PUT: begin
                attr = shadow_color;
                // rainbow hue advances on every put, newlines included
                if (shadow_rainbow) begin
                    if (it.first) shadow_hue = RAINBOW_FIRST;
                    attr = {4'h0, shadow_hue};
                    shadow_hue = (shadow_hue == RAINBOW_LAST) ? RAINBOW_FIRST : shadow_hue + 4'd1;
                end
                if (it.ch == NEWLINE_CHAR) begin
                    line_feed(attr, rolled);
                end else begin
                    shadow_screen[shadow_row * COLUMNS + shadow_col] = {attr, it.ch};
                    shadow_col++;
                    if (shadow_col >= COLUMNS) line_feed(attr, rolled);
                end
            end
            OP_READ: begin
                if (it.idx < CELLS) res.value = shadow_screen[it.idx];
            end
            OP_CLEAR: begin
                fill_shadow(shadow_color);
                shadow_row = 0;
                shadow_col = 0;
            end
            default: ;
        endcase
        res.row = 5'(shadow_row);
        res.col = 7'(shadow_col);
        res.scrolled = rolled;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("mismatch %s: got 0x%0h, expected 0x%0h, cycle %0d", what, got, want, cycles);
    endtask

    // Result monitor: one beat per o_done cycle, compared against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", o_cell_value, 0);
            end else begin
                oldest_result = pending_results.pop_front();
                if (o_cell_value !== oldest_result.value)
                    report_mismatch("cell_value", o_cell_value, oldest_result.value);
                if (o_cursor_row !== oldest_result.row)
                    report_mismatch("cursor_row", o_cursor_row, oldest_result.row);
                if (o_cursor_column !== oldest_result.col)
                    report_mismatch("cursor_column", o_cursor_column, oldest_result.col);
                if (o_scrolled !== oldest_result.scrolled)
                    report_mismatch("scrolled", o_scrolled, oldest_result.scrolled);
            end
        end
    end

    // Drive one item beat; the expectation is queued at the accepting edge
    task automatic send_item(input t_console_item it, input bit typed,
                             input t_console_result want);
        t_console_result res;
        @(negedge i_clk);
        if ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge i_clk);
        end
        start <= 1'b1;
        i_op <= it.op;
        i_character <= it.ch;
        i_first <= it.first;
        i_cell_index <= it.idx;
        do @(posedge i_clk); while (busy);
        console_step(it, res);
        pending_results.push_back(typed ? want : res);
    endtask

    // Register write, only once the console has drained
    task automatic write_reg(input logic [0:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_TEXT_COLOR) shadow_color = val;
        else shadow_rainbow = val[0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly puts with frequent newlines so the screen scrolls often
    function automatic t_console_item random_item();
        t_console_item it;
        int pick;
        it.op = OP_PUT;
        it.ch = 8'($urandom);
        it.first = ($urandom_range(99) < 15);
        it.idx = 11'($urandom);
        pick = $urandom_range(999);
        if (pick < 4) begin
            it.op = OP_CLEAR;
        end else if (pick < 20) begin
            it.op = OP_NONE;
        end else if (pick < 220) begin
            it.op = OP_READ;
            case ($urandom_range(9))
                0: it.idx = 11'($urandom_range(2047, CELLS));
                1, 2, 3, 4: it.idx = 11'(shadow_row * COLUMNS + $urandom_range(COLUMNS - 1));
                default: it.idx = 11'($urandom_range(CELLS - 1));
            endcase
        end else if ($urandom_range(99) < 20) begin
            it.ch = NEWLINE_CHAR;
        end
        return it;
    endfunction

    function automatic t_directed_row item_row(input t_op op, input logic [7:0] ch,
                                               input logic first, input logic [10:0] idx,
                                               input int reps = 1);
        t_directed_row r;
        r.kind = ROW_ITEM;
        r.item = '{op, ch, first, idx};
        r.reps = reps;
        r.typed = 1'b0;
        r.want = '0;
        r.reg_idx = '0;
        r.reg_val = '0;
        return r;
    endfunction

    function automatic t_directed_row typed_row(input t_op op, input logic [7:0] ch,
                                                input logic first, input logic [10:0] idx,
                                                input logic [15:0] value, input int row,
                                                input int col);
        t_directed_row r;
        r = item_row(op, ch, first, idx);
        r.typed = 1'b1;
        r.want = '{value, 5'(row), 7'(col), 1'b0};
        return r;
    endfunction

    function automatic t_directed_row cfg_row(input logic [0:0] idx, input logic [7:0] val);
        t_directed_row r;
        r = item_row(OP_NONE, 8'h00, 1'b0, 11'd0, 0);
        r.kind = ROW_CFG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_op = OP_PUT;
        i_character = 8'h00;
        i_first = 1'b0;
        i_cell_index = 11'd0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_TEXT_COLOR;
        i_cfg_data = 8'h00;
        mismatches = 0;
        gap_pct = 9;
        shadow_row = 0;
        shadow_col = 0;
        shadow_hue = RAINBOW_FIRST;
        shadow_color = RESET_ATTR;
        shadow_rainbow = 1'b0;
        fill_shadow(RESET_ATTR);

        // After reset: blank screen, reads past the end, undefined op
        directed_rows.push_back(typed_row(OP_READ, 8'h00, 1'b0, 11'd0,
                                          {RESET_ATTR, SPACE_CHAR}, 0, 0));
        directed_rows.push_back(typed_row(OP_READ, 8'h00, 1'b0, 11'd1999,
                                          {RESET_ATTR, SPACE_CHAR}, 0, 0));
        directed_rows.push_back(typed_row(OP_READ, 8'h00, 1'b0, 11'd2000, 16'h0000, 0, 0));
        directed_rows.push_back(typed_row(OP_READ, 8'h00, 1'b0, 11'd2047, 16'h0000, 0, 0));
        directed_rows.push_back(typed_row(OP_NONE, 8'hFF, 1'b1, 11'd2047, 16'h0000, 0, 0));
        // Plain puts, character extremes, newline, read back
        directed_rows.push_back(item_row(OP_PUT, 8'h41, 1'b0, 11'd0));
        directed_rows.push_back(item_row(OP_PUT, 8'h00, 1'b0, 11'd0));
        directed_rows.push_back(item_row(OP_PUT, 8'hFF, 1'b1, 11'd0));
        directed_rows.push_back(item_row(OP_PUT, NEWLINE_CHAR, 1'b0, 11'd0));
        directed_rows.push_back(item_row(OP_READ, 8'h00, 1'b0, 11'd0));
        directed_rows.push_back(item_row(OP_READ, 8'h00, 1'b0, 11'd2));
        directed_rows.push_back(typed_row(OP_CLEAR, 8'h00, 1'b0, 11'd0, 16'h0000, 0, 0));
        directed_rows.push_back(typed_row(OP_READ, 8'h00, 1'b0, 11'd0,
                                          {RESET_ATTR, SPACE_CHAR}, 0, 0));
        // Rainbow: wrap of the hue, restart on first, newlines down to the last row, read back
        directed_rows.push_back(cfg_row(REG_TEXT_COLOR, 8'h00));
        directed_rows.push_back(cfg_row(REG_RAINBOW_MODE, 8'h01));
        directed_rows.push_back(item_row(OP_PUT, 8'h48, 1'b1, 11'd0));
        directed_rows.push_back(item_row(OP_PUT, 8'h69, 1'b0, 11'd0, 17));
        directed_rows.push_back(item_row(OP_PUT, 8'h48, 1'b1, 11'd0));
        directed_rows.push_back(item_row(OP_PUT, NEWLINE_CHAR, 1'b0, 11'd0, ROWS - 1));
        directed_rows.push_back(item_row(OP_READ, 8'h00, 1'b0, 11'd1999));
        directed_rows.push_back(item_row(OP_READ, 8'h00, 1'b0, 11'(CELLS - COLUMNS)));
        // Clear uses text_color, not the rainbow
        directed_rows.push_back(cfg_row(REG_RAINBOW_MODE, 8'h00));
        directed_rows.push_back(typed_row(OP_CLEAR, 8'h00, 1'b0, 11'd0, 16'h0000, 0, 0));
        directed_rows.push_back(typed_row(OP_READ, 8'h00, 1'b0, 11'd1000,
                                          {8'h00, SPACE_CHAR}, 0, 0));
        // Full attribute, one row filled to force the column wrap
        directed_rows.push_back(cfg_row(REG_TEXT_COLOR, 8'hFF));
        directed_rows.push_back(item_row(OP_PUT, 8'h5A, 1'b0, 11'd0, COLUMNS));
        directed_rows.push_back(item_row(OP_READ, 8'h00, 1'b0, 11'd79));

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            if (directed_rows[k].kind == ROW_CFG) begin
                write_reg(directed_rows[k].reg_idx, directed_rows[k].reg_val);
            end else begin
                repeat (directed_rows[k].reps)
                    send_item(directed_rows[k].item, directed_rows[k].typed,
                              directed_rows[k].want);
            end
        end

        // Random phases: light sender gaps, heavy gaps, then back to back
        for (int p = 0; p < 3; p++) begin
            gap_pct = (p == 0) ? 9 : (p == 1) ? 78 : 0;
            write_reg(REG_RAINBOW_MODE,
                      {7'd0, ((p == 0) ? 1'b0 : (p == 1) ? 1'b1 : 1'($urandom))});
            write_reg(REG_TEXT_COLOR, 8'($urandom));
            repeat (ITEMS_PER_PHASE) send_item(random_item(), 1'b0, '0);
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("text_console_writer_top regression: pass");
        end else begin
            $display("text_console_writer_top regression: fail");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/tcw_pkg.sv
hdl/tcw_front.sv
hdl/tcw_queue.sv
hdl/tcw_back.sv
hdl/text_console_writer_top.sv
hdl/tcw_checker.sv
tb/tb_text_console_writer_top.sv
